// ----- design/mhci_pkg.sv -----
// shared constants, types and specific heat tables for the mox heat capacity interpolator
package mhci_pkg;

    localparam int TABLE_CAP = 64;

    localparam logic [15:0] T_FIRST  = 16'd4800;
    localparam logic [10:0] T_STEP   = 11'd1600;
    localparam logic [16:0] FRAC_ONE = 17'd32768;
    localparam logic [19:0] RECIP_25 = 20'd671088;
    localparam logic [4:0]  DIV_25   = 5'd25;

    typedef logic [5:0]  t_idx;
    typedef logic [10:0] t_rem;
    typedef logic [15:0] t_entry;
    typedef logic [26:0] t_value;

    localparam t_entry CP_UO2 [TABLE_CAP] = '{
        0: 16'd15073,  1: 16'd17011,  2: 16'd18057,  3: 16'd18701,
        4: 16'd19143,  5: 16'd19471,  6: 16'd19732,  7: 16'd19951,
        8: 16'd20145,  9: 16'd20326, 10: 16'd20508, 11: 16'd20710,
        12: 16'd20954, 13: 16'd21268, 14: 16'd21681, 15: 16'd22227,
        16: 16'd22938, 17: 16'd23843, 18: 16'd24968, 19: 16'd26333,
        20: 16'd27954, 21: 16'd29837, 22: 16'd31987, 23: 16'd34400,
        24: 16'd37067, 25: 16'd39976, 26: 16'd43112, 27: 16'd46456,
        28: 16'd49989,
        default: 16'd0
    };

    localparam t_entry CP_PUO2 [TABLE_CAP] = '{
        0: 16'd13037,  1: 16'd14451,  2: 16'd15089,  3: 16'd15445,
        4: 16'd15675,  5: 16'd15838,  6: 16'd15964,  7: 16'd16067,
        8: 16'd16156,  9: 16'd16237, 10: 16'd16317, 11: 16'd16404,
        12: 16'd16508, 13: 16'd16636, 14: 16'd16798, 15: 16'd17003,
        16: 16'd17252, 17: 16'd17547, 18: 16'd17878, 19: 16'd18237,
        20: 16'd18611, 21: 16'd18989, 22: 16'd19358, 23: 16'd19712,
        24: 16'd20045, 25: 16'd20357, 26: 16'd20646, 27: 16'd20913,
        28: 16'd21161,
        default: 16'd0
    };

endpackage

// ----- design/mhci_index.sv -----
// three-stage breakpoint index and remainder with end clamping
module mhci_index #(
    parameter int TABLE_POINTS = 29
) (
    input  logic          i_clk,
    input  logic [2:0]    i_en,
    input  logic [15:0]   i_temperature,
    output mhci_pkg::t_idx o_idx,
    output mhci_pkg::t_rem o_rem
);
    import mhci_pkg::*;

    localparam int          Last    = TABLE_POINTS - 1;
    localparam logic [16:0] T_LAST  = 17'(int'(T_FIRST) + Last * int'(T_STEP));
    localparam t_idx        IDX_TOP = 6'(Last - 1);

    logic [15:0] r_d1;
    logic        r_lo1;
    logic        r_hi1;
    logic [15:0] r_d2;
    logic        r_lo2;
    logic        r_hi2;
    t_idx        r_i2;
    t_idx        r_i3;
    t_rem        r_r3;

    logic [15:0] n_prod;
    logic [16:0] n_base;
    logic [16:0] n_diff;
    t_idx        n_i3;
    t_rem        n_r3;

    // floor(d / 1600) as floor(floor(d / 64) * 41 / 1024), exact for d below 65536
    assign n_prod = 16'(r_d1[15:6]) * 16'd41;
    assign n_base = 17'(r_i2) * 17'(T_STEP);
    assign n_diff = {1'b0, r_d2} - n_base;

    always_comb begin
        n_i3 = r_i2;
        n_r3 = n_diff[10:0];
        if (r_lo2) begin
            n_i3 = '0;
            n_r3 = '0;
        end else if (r_hi2) begin
            n_i3 = IDX_TOP;
            n_r3 = T_STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_d1  <= i_temperature - T_FIRST;
            r_lo1 <= i_temperature <= T_FIRST;
            r_hi1 <= {1'b0, i_temperature} >= T_LAST;
        end
        if (i_en[1]) begin
            r_d2  <= r_d1;
            r_lo2 <= r_lo1;
            r_hi2 <= r_hi1;
            r_i2  <= n_prod[15:10];
        end
        if (i_en[2]) begin
            r_i3 <= n_i3;
            r_r3 <= n_r3;
        end
    end

    assign o_idx = r_i3;
    assign o_rem = r_r3;

endmodule

// ----- design/mhci_interp.sv -----
// table lookup and linear interpolation for both oxide tables
module mhci_interp (
    input  logic             i_clk,
    input  logic             i_en,
    input  mhci_pkg::t_idx   i_idx,
    input  mhci_pkg::t_rem   i_rem,
    output mhci_pkg::t_value o_vu,
    output mhci_pkg::t_value o_vp
);
    import mhci_pkg::*;

    t_idx   w_nxt;
    t_rem   w_wgt;
    t_value n_vu;
    t_value n_vp;
    t_value r_vu;
    t_value r_vp;

    assign w_nxt = i_idx + 6'd1;
    assign w_wgt = T_STEP - i_rem;

    assign n_vu = 27'(CP_UO2[i_idx]) * 27'(w_wgt) + 27'(CP_UO2[w_nxt]) * 27'(i_rem);
    assign n_vp = 27'(CP_PUO2[i_idx]) * 27'(w_wgt) + 27'(CP_PUO2[w_nxt]) * 27'(i_rem);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vu <= n_vu;
            r_vp <= n_vp;
        end
    end

    assign o_vu = r_vu;
    assign o_vp = r_vp;

endmodule

// ----- design/mhci_blend.sv -----
// fraction blend and truncating scale-down by 1600 * 32768, saturating at 16'hFFFF
module mhci_blend (
    input  logic             i_clk,
    input  logic [2:0]       i_en,
    input  logic [15:0]      i_frac,
    input  mhci_pkg::t_value i_vu,
    input  mhci_pkg::t_value i_vp,
    output logic [15:0]      o_heat
);
    import mhci_pkg::*;

    logic [43:0] n_mix;
    logic [43:0] r_mix;
    logic [22:0] n_x;
    logic [42:0] n_p;
    logic [22:0] r_x;
    logic [42:0] r_p;
    logic [18:0] n_qe;
    logic [22:0] n_back;
    logic [22:0] n_left;
    logic [18:0] n_q;
    logic [15:0] n_heat;
    logic [15:0] r_heat;

    assign n_mix = 44'(FRAC_ONE - 17'(i_frac)) * 44'(i_vu) + 44'(i_frac) * 44'(i_vp);

    // divide by 32768 * 64, then by 25 through a reciprocal off by at most one
    assign n_x = r_mix[43:21];
    assign n_p = 43'(n_x) * 43'(RECIP_25);

    assign n_qe   = r_p[42:24];
    assign n_back = 23'(n_qe) * 23'(DIV_25);
    assign n_left = r_x - n_back;

    always_comb begin
        n_q = n_qe;
        if (n_left >= 23'(DIV_25)) begin
            n_q = n_qe + 19'd1;
        end
        n_heat = n_q[15:0];
        if (n_q[18:16] != 3'd0) begin
            n_heat = 16'hFFFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_mix <= n_mix;
        end
        if (i_en[1]) begin
            r_x <= n_x;
            r_p <= n_p;
        end
        if (i_en[2]) begin
            r_heat <= n_heat;
        end
    end

    assign o_heat = r_heat;

endmodule

// ----- design/mox_heat_capacity_interp.sv -----
// top level of the mox specific heat interpolator
// an accepted input beat passes through the index, interp and blend stages to its output beat
// throughput: one beat per cycle; each pipeline stage holds only while the stage after it is full
// a stage with an empty slot keeps taking data, so bubbles close up behind a stalled output
// reset clears all stage valid bits and sets pu_fraction to 0; the tables are constant logic
module mox_heat_capacity_interp #(
    parameter int TABLE_POINTS = 29
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_temperature,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_heat_capacity
);
    import mhci_pkg::*;

    localparam int Stages = 7;

    logic [Stages-1:0] r_vld;
    logic [Stages-1:0] n_vld;
    logic [Stages-1:0] w_en;
    logic [15:0]       r_pu_fraction;
    t_idx              w_idx;
    t_rem              w_rem;
    t_value            w_vu;
    t_value            w_vp;

    always_comb begin
        w_en[Stages-1] = !r_vld[Stages-1] || !i_stall;
        for (int k = Stages - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
        n_vld = r_vld;
        for (int k = 0; k < Stages; k++) begin
            if (w_en[k]) begin
                n_vld[k] = (k == 0) ? i_valid : r_vld[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld         <= '0;
            r_pu_fraction <= '0;
        end else begin
            r_vld <= n_vld;
            if (i_cfg_wr_en) begin
                r_pu_fraction <= ({1'b0, i_cfg_wr_data} > FRAC_ONE) ? FRAC_ONE[15:0]
                                                                    : i_cfg_wr_data;
            end
        end
    end

    mhci_index #(
        .TABLE_POINTS(TABLE_POINTS)
    ) u_index (
        .i_clk         (i_clk),
        .i_en          (w_en[2:0]),
        .i_temperature (i_temperature),
        .o_idx         (w_idx),
        .o_rem         (w_rem)
    );

    mhci_interp u_interp (
        .i_clk (i_clk),
        .i_en  (w_en[3]),
        .i_idx (w_idx),
        .i_rem (w_rem),
        .o_vu  (w_vu),
        .o_vp  (w_vp)
    );

    mhci_blend u_blend (
        .i_clk  (i_clk),
        .i_en   (w_en[6:4]),
        .i_frac (r_pu_fraction),
        .i_vu   (w_vu),
        .i_vp   (w_vp),
        .o_heat (o_heat_capacity)
    );

    assign o_stall = !w_en[0];
    assign o_valid = r_vld[Stages-1];

endmodule

// ----- design/mhci_checker.sv -----
// port-level checks for the mox heat capacity interpolator and their bind
module mhci_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_heat_capacity
);

    // reset empties the pipeline
    ap_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output beat present right after reset");

    // input backs up only when the output is full and held
    ap_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output side can move");

    // a held output beat keeps its value
    ap_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_heat_capacity)))
        else $error("stalled output beat changed or dropped");

endmodule

bind mox_heat_capacity_interp mhci_checker u_mhci_checker (.*);

// ----- tb/tb_top.sv -----
// self-checking testbench for the mox specific heat interpolator
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mhci_pkg::*;

    localparam int TABLE_POINTS  = 29;
    localparam int ITEMS_PER_RUN = 130;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 40;
    localparam int NUM_FRACTIONS = 9;

    class heat_capacity_checker;
        logic [15:0] pu_fraction;
        logic [15:0] expected_cp_q[$];
        int unsigned mismatch_count;

        function new();
            pu_fraction    = 16'd0;
            mismatch_count = 0;
        endfunction

        function void set_fraction(input logic [15:0] frac);
            pu_fraction = frac;
        endfunction

        function longint unsigned table_entry(input bit pu_side, input longint unsigned k);
            return pu_side ? longint'(CP_PUO2[k]) : longint'(CP_UO2[k]);
        endfunction

        // table value at temp, scaled by the breakpoint step
        function longint unsigned scaled_cp(input bit pu_side, input logic [15:0] temp);
            longint unsigned seg;
            longint unsigned r;
            longint unsigned d;
            longint unsigned last;
            last = TABLE_POINTS - 1;
            if (longint'(temp) <= longint'(T_FIRST)) begin
                seg = 0;
                r   = 0;
            end else if (longint'(temp) >= longint'(T_FIRST) + last * longint'(T_STEP)) begin
                seg = last;
                r   = 0;
            end else begin
                d   = longint'(temp) - longint'(T_FIRST);
                seg = d / longint'(T_STEP);
                r   = d % longint'(T_STEP);
            end
            return table_entry(pu_side, seg) * (longint'(T_STEP) - r)
                 + table_entry(pu_side, seg + 1) * r;
        endfunction

        function logic [15:0] heat_capacity_for(input logic [15:0] temp);
            longint unsigned f;
            longint unsigned mix;
            longint unsigned res;
            f   = (longint'(pu_fraction) > longint'(FRAC_ONE)) ? longint'(FRAC_ONE)
                                                                : longint'(pu_fraction);
            mix = (longint'(FRAC_ONE) - f) * scaled_cp(1'b0, temp) + f * scaled_cp(1'b1, temp);
            res = mix / (longint'(T_STEP) * longint'(FRAC_ONE));
            if (res > 64'hFFFF) begin
                res = 64'hFFFF;
            end
            return res[15:0];
        endfunction

        function void note_temperature(input logic [15:0] temp);
            expected_cp_q.push_back(heat_capacity_for(temp));
        endfunction

        function int pending();
            return expected_cp_q.size();
        endfunction

        task report_mismatch(input string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            mismatch_count++;
        endtask

        task check_heat_capacity(input logic [15:0] got);
            logic [15:0] want;
            if (expected_cp_q.size() == 0) begin
                report_mismatch($sformatf("unexpected heat_capacity %0d", got));
            end else begin
                want = expected_cp_q.pop_front();
                if (got !== want) begin
                    report_mismatch($sformatf("heat_capacity %0d, expected %0d", got, want));
                end
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [15:0] i_cfg_wr_data;
    logic        i_valid;
    logic        o_stall;
    logic [15:0] i_temperature;
    logic        o_valid;
    logic        i_stall;
    logic [15:0] o_heat_capacity;

    heat_capacity_checker sb;
    bit tx_idle_on;
    bit rx_idle_on;
    bit hold_req;

    mox_heat_capacity_interp #(
        .TABLE_POINTS(TABLE_POINTS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_temperature  (i_temperature),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_heat_capacity(o_heat_capacity)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // output side: random stall bursts, one long hold on request
    initial begin
        i_stall <= 1'b0;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_heat_capacity(o_heat_capacity);
        end
    end

    task automatic send_temperature(input logic [15:0] temp);
        int unsigned gap;
        gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_temperature <= temp;
        do @(posedge i_clk); while (o_stall);
        sb.note_temperature(temp);
    endtask

    function automatic logic [15:0] pick_temperature();
        int unsigned k;
        k = $urandom_range(0, 28);
        case ($urandom_range(0, 9))
            0: begin
                return 16'($urandom_range(0, 4800));
            end
            1: begin
                return 16'($urandom_range(49600, 65535));
            end
            2: begin
                return 16'(4800 + 1600 * k);
            end
            3: begin
                return 16'(4800 + 1600 * k + $urandom_range(0, 2) - 1);
            end
            4: begin
                return 16'($urandom_range(0, 65535));
            end
            default: begin
                return 16'($urandom_range(4801, 49599));
            end
        endcase
    endfunction

    task automatic run_random(input int count);
        repeat (count) send_temperature(pick_temperature());
        i_valid <= 1'b0;
    endtask

    task automatic settle();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_fraction(input logic [15:0] frac);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= frac;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.set_fraction(frac);
    endtask

    initial begin
        logic [15:0] directed_temps[$];
        logic [15:0] fraction_plan[NUM_FRACTIONS];
        bit          last_run;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 16'd0;
        i_valid       <= 1'b0;
        i_temperature <= 16'd0;
        sb = new();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        hold_req   = 1'b0;
        directed_temps = '{16'd0, 16'd1, 16'd4799, 16'd4800, 16'd4801, 16'd6399, 16'd6400,
                           16'd6401, 16'd8000, 16'd27200, 16'd27999, 16'd48000, 16'd49599,
                           16'd49600, 16'd49601, 16'd65534, 16'hFFFF, 16'h5555, 16'hAAAA,
                           16'h8000};
        fraction_plan = '{16'd32768, 16'hFFFF, 16'd1, 16'd32767, 16'd32769,
                          16'($urandom_range(0, 65535)), 16'd16384, 16'd0,
                          16'($urandom_range(0, 32768))};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_temps[k]) begin
            send_temperature(directed_temps[k]);
        end
        run_random(ITEMS_PER_RUN);

        for (int k = 0; k < NUM_FRACTIONS; k++) begin
            last_run = (k == NUM_FRACTIONS - 1);
            settle();
            write_fraction(fraction_plan[k]);
            tx_idle_on = !last_run && ($urandom_range(0, 3) != 0);
            rx_idle_on = !last_run && ($urandom_range(0, 3) != 0);
            if (k == 2) begin
                hold_req = 1'b1;
            end
            run_random(ITEMS_PER_RUN);
        end

        settle();
        if (sb.pending() != 0) begin
            sb.report_mismatch($sformatf("%0d heat_capacity beats never arrived", sb.pending()));
        end
        if (sb.mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
